// ===== rtl/okm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package okm_pkg;

	// Results kept for one input word; later results are not reported
	localparam int RESULT_CAP = 64;

	// Command modes
	localparam logic [1:0] MODE_PUSH    = 2'd0;
	localparam logic [1:0] MODE_ORDERED = 2'd1;
	localparam logic [1:0] MODE_FINAL   = 2'd2;

	// Entry kinds that bypass ordering
	localparam logic [1:0] KIND_INTERVAL = 2'd1;
	localparam logic [1:0] KIND_COUNT    = 2'd2;

	// Result status codes
	localparam logic STATUS_EMIT = 1'b0;
	localparam logic STATUS_DROP = 1'b1;

	// One stored lane entry
	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] key;
		logic [63:0] payload;
	} entry_t;

	// Result word from the sequencer to the output stage
	typedef struct packed {
		logic        valid;
		entry_t      ent;
		logic [1:0]  lane;
		logic        status;
	} emit_t;

endpackage

`default_nettype wire

// ===== rtl/okm_entry_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module okm_entry_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 130
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/okm_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module okm_seq #(
	parameter int LANES      = 4,
	parameter int LANE_DEPTH = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	input  wire [1:0]                             mode,
	input  wire [1:0]                             lane,
	input  wire [1:0]                             kind,
	input  wire [63:0]                            sort_key,
	input  wire [63:0]                            payload,
	input  wire                                   count_unordered,
	output logic                                  busy,
	output logic                                  ram_we,
	output logic [$clog2(LANES*LANE_DEPTH)-1:0]   ram_waddr,
	output okm_pkg::entry_t                       ram_wdata,
	output logic [$clog2(LANES*LANE_DEPTH)-1:0]   ram_raddr,
	input  wire okm_pkg::entry_t                  ram_rdata,
	output okm_pkg::emit_t                        emit,
	output logic                                  done
);

	import okm_pkg::*;

	localparam int AW = $clog2(LANES * LANE_DEPTH);
	localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int HW = $clog2(LANE_DEPTH);
	localparam int FW = $clog2(LANE_DEPTH + 1);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_PUSH    = 8'b0000_0010,
		S_SETTLE  = 8'b0000_0100,
		S_EVAL    = 8'b0000_1000,
		S_SCAN    = 8'b0001_0000,
		S_EMIT_RD = 8'b0010_0000,
		S_EMIT    = 8'b0100_0000,
		S_DONE    = 8'b1000_0000
	} state_t;

	state_t          state_q;
	logic [LW-1:0]   cur_q;
	logic [LW-1:0]   best_q;
	logic [63:0]     best_key_q;
	logic            found_q;
	logic            merge_q;
	logic            all_q;
	logic            final_q;
	logic            lane_ok_q;
	logic [1:0]      in_lane_q;
	entry_t          in_ent_q;
	logic [63:0]     last_int_q;
	logic [63:0]     last_cnt_q;

	logic [HW-1:0]   head_q  [LANES];
	logic [FW-1:0]   fill_q  [LANES];
	logic            cacc_q  [LANES];
	logic            live_q  [LANES];
	logic [63:0]     keys_q  [LANES];

	// current lane view
	logic [HW-1:0]   cur_head;
	logic [FW-1:0]   cur_fill;
	logic            lane_full;
	logic [HW:0]     tail_sum;
	logic [HW-1:0]   tail_slot;
	logic [HW-1:0]   head_inc;
	logic [AW-1:0]   lane_base;
	logic            cur_is_last;

	// shared 64-bit compare unit
	logic [63:0]     cmp_a;
	logic [63:0]     cmp_b;
	logic            lt;

	// head evaluation and sequencing decisions
	logic            is_int;
	logic            is_cnt_chk;
	logic            ev_emit;
	logic            ev_pop;
	logic            ev_set_int;
	logic            ev_set_cnt;
	logic            ev_set_cacc;
	logic            ev_ordered;
	logic            settle_end;
	logic            settle_live;
	logic            all_n;
	logic            next_lane;
	logic            to_scan;
	logic            take;
	logic            found_n;
	logic [LW-1:0]   best_n;
	logic            pop;

	// lane addressing
	always_comb begin
		cur_head    = head_q[cur_q];
		cur_fill    = fill_q[cur_q];
		lane_full   = (cur_fill == FW'(LANE_DEPTH));
		tail_sum    = (HW+1)'(cur_head) + (HW+1)'(cur_fill);
		if (tail_sum >= (HW+1)'(LANE_DEPTH)) begin
			tail_sum = tail_sum - (HW+1)'(LANE_DEPTH);
		end
		tail_slot   = tail_sum[HW-1:0];
		head_inc    = (cur_head == HW'(LANE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
		lane_base   = AW'(cur_q) * AW'(LANE_DEPTH);
		cur_is_last = (cur_q == LW'(LANES - 1));
	end

	assign ram_raddr = lane_base + AW'(cur_head);
	assign ram_waddr = lane_base + AW'(tail_slot);
	assign ram_wdata = in_ent_q;
	assign ram_we    = (state_q == S_PUSH) && lane_ok_q && !lane_full;

	// compare operands: tick check in EVAL, min scan in SCAN
	always_comb begin
		is_int     = (ram_rdata.kind == KIND_INTERVAL);
		is_cnt_chk = (ram_rdata.kind == KIND_COUNT) && !cacc_q[cur_q];
		if (state_q == S_SCAN) begin
			cmp_a = keys_q[cur_q];
			cmp_b = best_key_q;
		end else begin
			cmp_a = is_int ? last_int_q : last_cnt_q;
			cmp_b = ram_rdata.key;
		end
		lt = (cmp_a < cmp_b);
	end

	// head evaluation
	always_comb begin
		ev_emit     = 1'b0;
		ev_pop      = 1'b0;
		ev_set_int  = 1'b0;
		ev_set_cnt  = 1'b0;
		ev_set_cacc = 1'b0;
		ev_ordered  = 1'b0;
		if (is_int) begin
			ev_emit    = lt;
			ev_set_int = lt;
			ev_pop     = 1'b1;
		end else if (is_cnt_chk) begin
			if (!lt) begin
				ev_pop = 1'b1;
			end else begin
				ev_set_cnt = 1'b1;
				if (count_unordered) begin
					ev_emit = 1'b1;
					ev_pop  = 1'b1;
				end else begin
					ev_set_cacc = 1'b1;
					ev_ordered  = 1'b1;
				end
			end
		end else begin
			ev_ordered = 1'b1;
		end
	end

	// end of a lane settle, and where to go next
	always_comb begin
		settle_end  = 1'b0;
		settle_live = 1'b0;
		if (state_q == S_SETTLE && cur_fill == '0) begin
			settle_end = 1'b1;
		end else if (state_q == S_EVAL && ev_ordered) begin
			settle_end  = 1'b1;
			settle_live = 1'b1;
		end
		all_n     = all_q & (settle_live | !settle_end);
		next_lane = settle_end && !merge_q && !cur_is_last;
		to_scan   = settle_end && !next_lane && (all_n || final_q);
		pop       = (state_q == S_EVAL && ev_pop) || (state_q == S_EMIT);
	end

	// min scan step, strict compare keeps the lowest lane on ties
	always_comb begin
		take    = live_q[cur_q] && (!found_q || lt);
		found_n = found_q | take;
		best_n  = take ? cur_q : best_q;
	end

	// result word
	always_comb begin
		emit.valid  = 1'b0;
		emit.ent    = ram_rdata;
		emit.lane   = 2'(cur_q);
		emit.status = STATUS_EMIT;
		case (state_q)
			S_PUSH: begin
				emit.valid  = lane_ok_q && lane_full;
				emit.ent    = in_ent_q;
				emit.lane   = in_lane_q;
				emit.status = STATUS_DROP;
			end
			S_EVAL: begin
				emit.valid = ev_emit;
			end
			S_EMIT: begin
				emit.valid = 1'b1;
			end
			default: begin
				emit.valid = 1'b0;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cur_q      <= '0;
			best_q     <= '0;
			best_key_q <= '0;
			found_q    <= 1'b0;
			merge_q    <= 1'b0;
			all_q      <= 1'b0;
			final_q    <= 1'b0;
			lane_ok_q  <= 1'b0;
			in_lane_q  <= '0;
			last_int_q <= '0;
			last_cnt_q <= '0;
			for (int i = 0; i < LANES; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
				cacc_q[i] <= 1'b0;
				live_q[i] <= 1'b0;
			end
		end else begin
			// lane pop
			if (pop) begin
				head_q[cur_q] <= head_inc;
				fill_q[cur_q] <= cur_fill - 1'b1;
				cacc_q[cur_q] <= 1'b0;
			end
			// tick bookkeeping
			if (state_q == S_EVAL) begin
				if (ev_set_int) begin
					last_int_q <= ram_rdata.key;
				end
				if (ev_set_cnt) begin
					last_cnt_q <= ram_rdata.key;
				end
				if (ev_set_cacc) begin
					cacc_q[cur_q] <= 1'b1;
				end
			end
			if (settle_end) begin
				live_q[cur_q] <= settle_live;
				all_q         <= all_n;
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						final_q   <= (mode == MODE_FINAL);
						in_lane_q <= lane;
						lane_ok_q <= (int'(lane) < LANES);
						// push works on its lane, reads start at lane 0
						cur_q     <= (mode == MODE_PUSH && int'(lane) < LANES) ?
							LW'(lane) : '0;
						merge_q   <= 1'b0;
						all_q     <= 1'b1;
						case (mode)
							MODE_PUSH: begin
								state_q <= S_PUSH;
							end
							MODE_ORDERED, MODE_FINAL: begin
								state_q <= S_SETTLE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_PUSH: begin
					if (ram_we) begin
						fill_q[cur_q] <= cur_fill + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_SETTLE, S_EVAL: begin
					if (state_q == S_SETTLE && !settle_end) begin
						state_q <= S_EVAL;
					end else if (state_q == S_EVAL && !settle_end) begin
						state_q <= S_SETTLE;
					end else if (next_lane) begin
						cur_q   <= cur_q + 1'b1;
						state_q <= S_SETTLE;
					end else if (to_scan) begin
						cur_q   <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					found_q <= found_n;
					best_q  <= best_n;
					if (take) begin
						best_key_q <= keys_q[cur_q];
					end
					if (!cur_is_last) begin
						cur_q <= cur_q + 1'b1;
					end else if (found_n) begin
						cur_q   <= best_n;
						state_q <= S_EMIT_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					merge_q <= 1'b1;
					state_q <= S_SETTLE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// latched push word and ordered head keys
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			in_ent_q.kind    <= kind;
			in_ent_q.key     <= sort_key;
			in_ent_q.payload <= payload;
		end
		if (state_q == S_EVAL && ev_ordered) begin
			keys_q[cur_q] <= ram_rdata.key;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ordered_kway_result_merger.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ordered k-way result merger.
// Command channel: an item is taken at a clock edge with start high and busy
// low. mode selects push (append kind/sort_key/payload to lane), ordered read
// or final drain read. busy stays high until the command is finished.
// Result channel: each result word is on the out_* ports, status and last for
// one cycle with out_valid high; the receiver cannot stall it. last marks
// the final word caused by one command. A word is held one step so that last
// can be set, so it appears once the next result is found or the command ends.
// Configuration: cfg_data bit 0 is written when cfg_valid is high (cfg_ready
// is always high); it selects whether count ticks bypass ordering.
// Sequence: after acceptance a push passes through the push and done states, so
// a new command is taken only once the push is back in idle. A read settles each
// lane head through the entry RAM read port, alternating settle and eval states
// for each head entry; each ordered result then takes a key scan of every lane
// on the shared 64-bit comparator, a read and pop, and a settle of the new head.
// At reset all lanes are empty, tick history is zero and count ticks bypass
// ordering. The entry RAM needs no clearing pass.

module ordered_kway_result_merger #(
	parameter int LANES      = 4,
	parameter int LANE_DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire [1:0]   mode,
	input  wire [1:0]   lane,
	input  wire [1:0]   kind,
	input  wire [63:0]  sort_key,
	input  wire [63:0]  payload,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_data,
	output logic        out_valid,
	output logic [1:0]  out_kind,
	output logic [63:0] out_key,
	output logic [63:0] out_payload,
	output logic [1:0]  out_lane,
	output logic        status,
	output logic        last
);

	import okm_pkg::*;

	localparam int SLOTS = LANES * LANE_DEPTH;
	localparam int AW    = $clog2(SLOTS);
	localparam int CW    = $clog2(RESULT_CAP + 1);

	logic            ctu_q;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [AW-1:0]   ram_raddr;
	entry_t          ram_wdata;
	entry_t          ram_rdata;
	emit_t           em;
	logic            done;
	logic            emit_take;

	emit_t           pend_q;
	logic [CW-1:0]   cnt_q;

	logic            out_valid_q;
	logic            last_q;
	emit_t           out_q;

	okm_entry_ram #(
		.DEPTH (SLOTS),
		.WIDTH ($bits(entry_t))
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	okm_seq #(
		.LANES      (LANES),
		.LANE_DEPTH (LANE_DEPTH)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.mode            (mode),
		.lane            (lane),
		.kind            (kind),
		.sort_key        (sort_key),
		.payload         (payload),
		.count_unordered (ctu_q),
		.busy            (busy),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata),
		.ram_raddr       (ram_raddr),
		.ram_rdata       (ram_rdata),
		.emit            (em),
		.done            (done)
	);

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctu_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			ctu_q <= cfg_data;
		end
	end

	// results past the cap are not reported
	assign emit_take = em.valid && (cnt_q < CW'(RESULT_CAP));

	// one-word hold so the final word of a command can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			out_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
			if (start && !busy) begin
				cnt_q <= '0;
			end
			if (emit_take) begin
				cnt_q       <= cnt_q + 1'b1;
				pend_q      <= em;
				out_q       <= pend_q;
				out_valid_q <= pend_q.valid;
			end else if (done) begin
				pend_q.valid <= 1'b0;
				out_q        <= pend_q;
				out_valid_q  <= pend_q.valid;
				last_q       <= 1'b1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_kind    = out_q.ent.kind;
	assign out_key     = out_q.ent.key;
	assign out_payload = out_q.ent.payload;
	assign out_lane    = out_q.lane;
	assign status      = out_q.status;
	assign last        = last_q;

endmodule

`default_nettype wire
